@@ design/rti_pkg.sv @@
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types and constants of the ray/triangle intersection unit.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int unsigned PackW = 63;
  localparam int unsigned OutW  = 32;

  typedef struct packed {
    logic [PackW-1:0] vertex0;
    logic [PackW-1:0] vertex1;
    logic [PackW-1:0] vertex2;
    logic [PackW-1:0] ray_origin;
    logic [PackW-1:0] ray_direction;
  } rti_req_t;

  typedef struct packed {
    logic                   hit;
    logic signed [OutW-1:0] hit_x;
    logic signed [OutW-1:0] hit_y;
    logic signed [OutW-1:0] hit_z;
  } rti_rsp_t;

endpackage

@@ design/rti_if.sv @@
// ----------------------------------------------------------------------------
// rti_req_if / rti_rsp_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
interface rti_req_if;
  logic              valid;
  logic              ready;
  rti_pkg::rti_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rti_rsp_if;
  logic              valid;
  logic              ready;
  rti_pkg::rti_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/rti_div.sv @@
// ----------------------------------------------------------------------------
// rti_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// Carries a side payload; advances on en_i.
// ----------------------------------------------------------------------------
module rti_div #(
  parameter int unsigned NumW  = 80,
  parameter int unsigned DenW  = 64,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NumW-1:0]  num_i,
  input  logic [DenW-1:0]  den_i,
  input  logic [SideW-1:0] side_i,
  output logic [NumW-1:0]  quo_o,
  output logic [SideW-1:0] side_o
);

  logic [NumW-1:0]  n_q    [1:NumW];
  logic [DenW:0]    r_q    [1:NumW];
  logic [DenW-1:0]  d_q    [1:NumW];
  logic [SideW-1:0] s_q    [1:NumW];

  for (genvar g = 0; g < NumW; g++) begin : g_stage
    logic [NumW-1:0]  n_in;
    logic [DenW:0]    r_in;
    logic [DenW-1:0]  d_in;
    logic [SideW-1:0] s_in;
    logic [DenW+1:0]  sh;
    logic [DenW+1:0]  df;
    if (g == 0) begin : g_first
      assign n_in = num_i;
      assign r_in = '0;
      assign d_in = den_i;
      assign s_in = side_i;
    end else begin : g_next
      assign n_in = n_q[g];
      assign r_in = r_q[g];
      assign d_in = d_q[g];
      assign s_in = s_q[g];
    end
    assign sh = {r_in, n_in[NumW-1]};
    assign df = sh - {2'b0, d_in};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!df[DenW+1]) begin
          r_q[g+1] <= df[DenW:0];
          n_q[g+1] <= {n_in[NumW-2:0], 1'b1};
        end else begin
          r_q[g+1] <= sh[DenW:0];
          n_q[g+1] <= {n_in[NumW-2:0], 1'b0};
        end
        d_q[g+1] <= d_in;
        s_q[g+1] <= s_in;
      end
    end
  end

  assign quo_o  = n_q[NumW];
  assign side_o = s_q[NumW];

endmodule

@@ design/ray_triangle_intersect_unit.sv @@
// ----------------------------------------------------------------------------
// ray_triangle_intersect_unit
// Fixed-point Moller-Trumbore ray/triangle test with hit point.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one request per cycle when ready: three triangle vertices, a ray
//   origin and a ray direction, each three packed signed COORD_WIDTH-bit
//   components (x at bit 0). rsp_if returns one result per request, in order:
//   hit flag and the saturated hit point (zero on a miss).
// Pipeline: 8 front stages (edges, cross products, cross differences, dot
//   terms, sums and sign fold, tests, split |d|*t' products, their sum), one
//   stage per quotient bit in the divider (4*COORD_WIDTH+6 bits), plus the
//   saturation register.
// Throughput: one request per cycle. The whole pipe advances as one unit:
//   it moves whenever the output register is empty or being drained, so a
//   stalled receiver holds every stage; nothing is dropped or repeated.
// Reset: asynchronous, active low; clears all valid bits. Payload registers
//   are not reset.
// Division: one signed tn/a division per component, done as an unsigned
//   restoring pipeline on |d|*t' over |a|, sign reapplied afterwards.
// ----------------------------------------------------------------------------
module ray_triangle_intersect_unit #(
  parameter int unsigned COORD_WIDTH = 21,
  parameter int unsigned FRAC_BITS   = 8
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  rti_req_if.sink   req_if,
  rti_rsp_if.source rsp_if
);
  import rti_pkg::*;

  // FRAC_BITS only names the coordinate format: every term scales alike, so
  // the hit point does not depend on it.
  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned EW = CW + 1;          // edges, s
  localparam int unsigned HW = 2 * EW + 1;      // cross products
  localparam int unsigned AW = HW + EW + 2;     // dot products
  localparam int unsigned NW = AW + CW;         // |d| * t'
  localparam int unsigned TLoW = AW / 2;        // low slice of t'
  localparam int unsigned THiW = AW - TLoW;     // high slice of t'
  localparam int unsigned NumStg = 8;

  logic adv;
  logic [NumStg-1:0] vld_q;

  typedef logic signed [CW-1:0] crd_t;
  typedef logic signed [EW-1:0] edg_t;
  typedef logic signed [HW-1:0] crs_t;
  typedef logic signed [AW-1:0] dot_t;

  function automatic crd_t comp(input logic [PackW-1:0] w, input int unsigned k);
    comp = w[k*CW +: CW];
  endfunction

  // ---- stage 1: unpack, edges, s
  crd_t p1_q [3], d1_q [3];
  edg_t e1_q [3], e2_q [3], s1_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        p1_q[k] <= comp(req_if.data.ray_origin, k);
        d1_q[k] <= comp(req_if.data.ray_direction, k);
        e1_q[k] <= EW'(comp(req_if.data.vertex1, k)) - EW'(comp(req_if.data.vertex0, k));
        e2_q[k] <= EW'(comp(req_if.data.vertex2, k)) - EW'(comp(req_if.data.vertex0, k));
        s1_q[k] <= EW'(comp(req_if.data.ray_origin, k)) - EW'(comp(req_if.data.vertex0, k));
      end
    end
  end

  // ---- stage 2: h = d x e2, q = s x e1 (products registered)
  crs_t hp_q [6], qp_q [6];
  crd_t p2_q [3], d2_q [3];
  edg_t e12_q [3], e22_q [3], s2_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        hp_q[2*k]   <= HW'(EW'(d1_q[(k+1)%3]) * e2_q[(k+2)%3]);
        hp_q[2*k+1] <= HW'(EW'(d1_q[(k+2)%3]) * e2_q[(k+1)%3]);
        qp_q[2*k]   <= HW'(s1_q[(k+1)%3] * e1_q[(k+2)%3]);
        qp_q[2*k+1] <= HW'(s1_q[(k+2)%3] * e1_q[(k+1)%3]);
      end
      p2_q <= p1_q; d2_q <= d1_q; e12_q <= e1_q; e22_q <= e2_q; s2_q <= s1_q;
    end
  end

  // ---- stage 3: cross differences
  crs_t h3_q [3], q3_q [3];
  crd_t p3_q [3], d3_q [3];
  edg_t e13_q [3], e23_q [3], s3_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        h3_q[k] <= hp_q[2*k] - hp_q[2*k+1];
        q3_q[k] <= qp_q[2*k] - qp_q[2*k+1];
      end
      p3_q <= p2_q; d3_q <= d2_q; e13_q <= e12_q; e23_q <= e22_q; s3_q <= s2_q;
    end
  end

  // ---- stage 4: dot-product terms
  dot_t at_q [3], ut_q [3], vt_q [3], tt_q [3];
  crd_t p4_q [3], d4_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        at_q[k] <= AW'(AW'(e13_q[k]) * AW'(h3_q[k]));
        ut_q[k] <= AW'(AW'(s3_q[k]) * AW'(h3_q[k]));
        vt_q[k] <= AW'(AW'(d3_q[k]) * AW'(q3_q[k]));
        tt_q[k] <= AW'(AW'(e23_q[k]) * AW'(q3_q[k]));
      end
      p4_q <= p3_q; d4_q <= d3_q;
    end
  end

  // ---- stage 5: sums and sign fold
  dot_t a5_q, u5_q, v5_q, t5_q;
  logic az5_q;
  crd_t p5_q [3], d5_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dot_t a, u, v, t;
      a = at_q[0] + at_q[1] + at_q[2];
      u = ut_q[0] + ut_q[1] + ut_q[2];
      v = vt_q[0] + vt_q[1] + vt_q[2];
      t = tt_q[0] + tt_q[1] + tt_q[2];
      az5_q <= (a == '0);
      a5_q  <= a[AW-1] ? -a : a;
      u5_q  <= a[AW-1] ? -u : u;
      v5_q  <= a[AW-1] ? -v : v;
      t5_q  <= a[AW-1] ? -t : t;
      p5_q <= p4_q; d5_q <= d4_q;
    end
  end

  // ---- stage 6: hit tests
  logic hit6_q;
  dot_t a6_q, t6_q;
  crd_t p6_q [3], d6_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic signed [AW:0] uv;
      uv = {u5_q[AW-1], u5_q} + {v5_q[AW-1], v5_q};
      hit6_q <= !az5_q && !u5_q[AW-1] && !v5_q[AW-1] && !t5_q[AW-1]
                && (uv <= $signed({1'b0, a5_q}));
      a6_q <= a5_q; t6_q <= t5_q; p6_q <= p5_q; d6_q <= d5_q;
    end
  end

  // ---- stage 7: |d| times the low and high slices of t'
  logic [CW+TLoW-1:0] pl7_q [3];
  logic [CW+THiW-1:0] ph7_q [3];
  logic               dn7_q [3];
  logic               hit7_q;
  logic [AW-1:0]      a7_q;
  crd_t               p7_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic [CW-1:0] m;
        logic [AW-1:0] tu;
        m  = d6_q[k][CW-1] ? CW'(-d6_q[k]) : CW'(d6_q[k]);
        tu = t6_q;
        pl7_q[k] <= (CW+TLoW)'(m) * (CW+TLoW)'(tu[TLoW-1:0]);
        ph7_q[k] <= (CW+THiW)'(m) * (CW+THiW)'(tu[AW-1:TLoW]);
        dn7_q[k] <= d6_q[k][CW-1];
      end
      hit7_q <= hit6_q;
      a7_q   <= hit6_q ? a6_q : AW'(1);
      p7_q   <= p6_q;
    end
  end

  // ---- stage 8: |d| * t' from the two slices
  logic [NW-1:0] n8_q [3];
  logic          dn8_q [3];
  logic          hit8_q;
  logic [AW-1:0] a8_q;
  crd_t          p8_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        n8_q[k] <= NW'(pl7_q[k]) + (NW'(ph7_q[k]) << TLoW);
      end
      dn8_q  <= dn7_q;
      hit8_q <= hit7_q;
      a8_q   <= a7_q;
      p8_q   <= p7_q;
    end
  end

  // ---- divider pipelines
  localparam int unsigned SideW = 1 + CW + 1;
  logic [NW-1:0]    quo  [3];
  logic [SideW-1:0] side [3];
  for (genvar k = 0; k < 3; k++) begin : g_div
    rti_div #(.NumW(NW), .DenW(AW), .SideW(SideW)) u_div (
      .clk_i  (clk_i),
      .en_i   (adv),
      .num_i  (n8_q[k]),
      .den_i  (a8_q),
      .side_i ({hit8_q, p8_q[k], dn8_q[k]}),
      .quo_o  (quo[k]),
      .side_o (side[k])
    );
  end

  logic [NW-1:0] dvld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dvld_q <= '0;
    else if (adv) dvld_q <= {dvld_q[NW-2:0], vld_q[NumStg-1]};
  end

  // ---- output: sign, add, saturate
  rti_rsp_t rsp_q;
  logic     ov_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic signed [OutW-1:0] r [3];
      for (int k = 0; k < 3; k++) begin
        logic signed [NW+1:0] tot;
        logic signed [NW+1:0] off;
        off = $signed({2'b0, quo[k]});
        if (side[k][0]) off = -off;
        tot = off + (NW+2)'($signed(side[k][CW:1]));
        if (tot < -(NW+2)'(64'sh80000000))       r[k] = 32'sh80000000;
        else if (tot > (NW+2)'(64'sh7fffffff))   r[k] = 32'sh7fffffff;
        else                                       r[k] = tot[OutW-1:0];
        if (!side[k][SideW-1]) r[k] = '0;
      end
      rsp_q.hit   <= side[0][SideW-1];
      rsp_q.hit_x <= r[0];
      rsp_q.hit_y <= r[1];
      rsp_q.hit_z <= r[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ov_q  <= 1'b0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStg-2:0], req_if.valid};
      ov_q  <= dvld_q[NW-1];
    end
  end

  assign adv          = !ov_q || rsp_if.ready;
  assign req_if.ready = adv;
  assign rsp_if.valid = ov_q;
  assign rsp_if.data  = rsp_q;

endmodule
